// File: hw/rtl/efd_pkg.sv
// Shared types and constants for the escaped frame deframer.
// Holds beat structs, the register map and frame capacity; no dependencies.
`default_nettype none
package efd_pkg;

  localparam int MaxFrameBytes = 1024;
  localparam int LenW          = $clog2(MaxFrameBytes + 1);
  localparam int FrameLenW     = 11;
  localparam int QDepth        = 4;
  localparam int QPtrW         = $clog2(QDepth);
  localparam int QCntW         = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    REG_SYNC       = 2'd0,
    REG_ESCAPE     = 2'd1,
    REG_RAW_SYNC   = 2'd2,
    REG_RAW_ESCAPE = 2'd3
  } reg_idx_t;

  localparam logic [7:0] SyncReset      = 8'd126;
  localparam logic [7:0] EscapeReset    = 8'd125;
  localparam logic [7:0] RawSyncReset   = 8'd94;
  localparam logic [7:0] RawEscapeReset = 8'd93;

  typedef struct packed {
    logic [7:0] sync_code;
    logic [7:0] escape_code;
    logic [7:0] raw_sync_code;
    logic [7:0] raw_escape_code;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic                 byte_valid;
    logic [7:0]           data_byte;
    logic                 stray_byte;
    logic                 frame_end;
    logic [FrameLenW-1:0] frame_length;
    logic                 bad_escape;
    logic                 overflow;
  } cmd_t;

  typedef struct packed {
    logic                 byte_valid;
    logic [7:0]           data_byte;
    logic                 stray_byte;
    logic                 frame_end;
    logic [FrameLenW-1:0] frame_length;
    logic                 bad_escape;
    logic                 overflow;
    logic [31:0]          frames_received;
    logic [31:0]          stray_count;
  } out_t;

endpackage
`default_nettype wire

// File: hw/rtl/efd_front.sv
// Front end: accepts raw bytes, tracks framing state and classifies each beat.
// Depends on efd_pkg; pushes result commands into efd_queue.
`default_nettype none
module efd_front (
  input  wire                  clk,
  input  wire                  rst,
  input  efd_pkg::cfg_t        cfg,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  efd_pkg::in_t         in_data,
  input  wire                  q_full,
  output logic                 push,
  output efd_pkg::cmd_t        push_cmd
);
  import efd_pkg::*;

  logic            in_frame, in_frame_next;
  logic            escape_pending, escape_pending_next;
  logic [LenW-1:0] length_so_far, length_so_far_next;
  logic            overflowed, overflowed_next;
  logic            accept;
  logic            emit;
  logic            room;
  logic [LenW-1:0] stored_len;
  logic            stored_ovf;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  assign room       = length_so_far < LenW'(MaxFrameBytes);
  assign stored_len = room ? length_so_far + LenW'(1) : length_so_far;
  assign stored_ovf = overflowed || !room;

  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    length_so_far_next  = length_so_far;
    overflowed_next     = overflowed;
    emit                = 1'b0;
    push_cmd            = '0;
    priority if (in_data.mode) begin
      length_so_far_next = '0;
      overflowed_next    = 1'b0;
    end else if (!in_frame) begin
      if (in_data.rx_byte == cfg.sync_code) begin
        in_frame_next = 1'b1;
      end else begin
        emit                = 1'b1;
        push_cmd.data_byte  = in_data.rx_byte;
        push_cmd.stray_byte = 1'b1;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      emit                = 1'b1;
      push_cmd.byte_valid = room;
      if (in_data.rx_byte == cfg.raw_sync_code || in_data.rx_byte == cfg.raw_escape_code) begin
        push_cmd.data_byte = (in_data.rx_byte == cfg.raw_sync_code) ?
                             cfg.sync_code : cfg.escape_code;
        push_cmd.overflow  = stored_ovf;
        length_so_far_next = stored_len;
        overflowed_next    = stored_ovf;
      end else begin
        push_cmd.data_byte    = cfg.sync_code;
        push_cmd.frame_end    = 1'b1;
        push_cmd.frame_length = FrameLenW'(stored_len);
        push_cmd.bad_escape   = 1'b1;
        push_cmd.overflow     = stored_ovf;
        in_frame_next         = 1'b0;
        length_so_far_next    = '0;
        overflowed_next       = 1'b0;
      end
    end else if (in_data.rx_byte == cfg.escape_code) begin
      escape_pending_next = 1'b1;
    end else if (in_data.rx_byte == cfg.sync_code) begin
      if (length_so_far != '0) begin
        emit                  = 1'b1;
        push_cmd.frame_end    = 1'b1;
        push_cmd.frame_length = FrameLenW'(length_so_far);
        push_cmd.overflow     = overflowed;
        in_frame_next         = 1'b0;
        length_so_far_next    = '0;
        overflowed_next       = 1'b0;
      end
    end else begin
      emit                = 1'b1;
      push_cmd.byte_valid = room;
      push_cmd.data_byte  = in_data.rx_byte;
      push_cmd.overflow   = stored_ovf;
      length_so_far_next  = stored_len;
      overflowed_next     = stored_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      length_so_far  <= '0;
      overflowed     <= 1'b0;
    end else if (accept) begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      length_so_far  <= length_so_far_next;
      overflowed     <= overflowed_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/efd_queue.sv
// Short command queue between front end and back end.
// Depends on efd_pkg for the command type and depth.
`default_nettype none
module efd_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  efd_pkg::cmd_t  push_cmd,
  output logic           full,
  input  wire            pop,
  output logic           not_empty,
  output efd_pkg::cmd_t  head
);
  import efd_pkg::*;

  cmd_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_pop;

  assign full      = count == QCntW'(QDepth);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCntW'(1);
      end else if (do_pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/efd_back.sv
// Back end: drains commands, keeps frame and stray counters, holds the output beat.
// Depends on efd_pkg; fed by efd_queue.
`default_nettype none
module efd_back (
  input  wire            clk,
  input  wire            rst,
  input  wire            q_not_empty,
  input  efd_pkg::cmd_t  q_head,
  output logic           pop,
  output logic           out_valid,
  input  wire            out_ready,
  output efd_pkg::out_t  out_data
);
  import efd_pkg::*;

  logic [31:0] frame_count, frame_count_next;
  logic [31:0] stray_total, stray_total_next;

  assign pop              = q_not_empty && (!out_valid || out_ready);
  assign frame_count_next = frame_count + {31'd0, q_head.frame_end};
  assign stray_total_next = stray_total + {31'd0, q_head.stray_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      frame_count <= '0;
      stray_total <= '0;
    end else if (pop) begin
      out_valid   <= 1'b1;
      frame_count <= frame_count_next;
      stray_total <= stray_total_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.byte_valid      <= q_head.byte_valid;
      out_data.data_byte       <= q_head.data_byte;
      out_data.stray_byte      <= q_head.stray_byte;
      out_data.frame_end       <= q_head.frame_end;
      out_data.frame_length    <= q_head.frame_length;
      out_data.bad_escape      <= q_head.bad_escape;
      out_data.overflow        <= q_head.overflow;
      out_data.frames_received <= frame_count_next;
      out_data.stray_count     <= stray_total_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/escaped_frame_deframer_core.sv
// Byte-stuffing receive deframer: one raw byte per cycle in while in_ready is high, decoded beats out.
// A result beat is registered into the queue and then into the output beat before out_valid shows it.
// Throughput: one input beat per cycle while in_ready is high; a four-entry queue lets the input keep
// flowing while the output stalls, and in_ready falls only when that queue is full.
// Reset (rst, synchronous): hunting, counters zero, codes back to 126/125/94/93.
// Depends on efd_pkg, efd_front, efd_queue, efd_back.
`default_nettype none
module escaped_frame_deframer_core (
  input  wire            clk,
  input  wire            rst,
  input  wire            cfg_we,
  input  wire [1:0]      cfg_index,
  input  wire [7:0]      cfg_data,
  input  wire            in_valid,
  output logic           in_ready,
  input  efd_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output efd_pkg::out_t  out_data
);
  import efd_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_not_empty;
  logic pop;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_code       <= SyncReset;
      cfg.escape_code     <= EscapeReset;
      cfg.raw_sync_code   <= RawSyncReset;
      cfg.raw_escape_code <= RawEscapeReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SYNC:       cfg.sync_code       <= cfg_data;
        REG_ESCAPE:     cfg.escape_code     <= cfg_data;
        REG_RAW_SYNC:   cfg.raw_sync_code   <= cfg_data;
        REG_RAW_ESCAPE: cfg.raw_escape_code <= cfg_data;
        default:        cfg.sync_code       <= cfg.sync_code;
      endcase
    end
  end

  efd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  efd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  efd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
